>>> src/srrw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the selective-repeat receive window.
// No dependencies; imported by every module of the block.
package srrw_pkg;

    localparam int WINDOW = 16;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int FL_W   = 24;
    localparam int SEG_W  = 16;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    localparam logic [1:0] CFG_FILE_LEN = 2'd0;
    localparam logic [1:0] CFG_SEG_SIZE = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

    localparam logic [FL_W-1:0]  FILE_LEN_RST = 24'd1;
    localparam logic [SEG_W-1:0] SEG_SIZE_RST = 16'd1000;
    localparam logic [SEG_W-1:0] TIMEOUT_RST  = 16'd1000;

    typedef enum logic [1:0] {
        KIND_REQ  = 2'd0,
        KIND_DLV  = 2'd1,
        KIND_IGN  = 2'd2,
        KIND_DONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [FL_W-1:0]  data_start;
        logic [SEG_W-1:0] data_length;
    } t_in_item;

    typedef struct packed {
        t_kind            kind;
        logic [FL_W-1:0]  request_offset;
        logic [SEG_W-1:0] request_length;
        logic [4:0]       deliver_slot;
        logic [FL_W-1:0]  deliver_segment;
        logic [SEG_W-1:0] deliver_length;
        logic             last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_N,
        ST_WAIT_N,
        ST_DISPATCH,
        ST_SW_RD,
        ST_SW_EX,
        ST_DIV_K,
        ST_WAIT_K,
        ST_BASE,
        ST_SLOT,
        ST_DLV,
        ST_FINISH,
        ST_FLUSH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_DIV_N,
        CMD_SAVE_N,
        CMD_START_INIT,
        CMD_TICK_INIT,
        CMD_SW_RD,
        CMD_SW_EX,
        CMD_DIV_K,
        CMD_BASE,
        CMD_ACCEPT,
        CMD_IGNORE,
        CMD_DLV,
        CMD_FINISH,
        CMD_FLUSH
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       div_busy;
        logic       active;
        logic       win_ok;
        logic       idx_last;
        logic       slot_ok;
        logic       dlv_go;
    } t_status;

endpackage

>>> src/srrw_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 24-bit dividend by 16-bit divisor.
// Depends on srrw_pkg.
module srrw_div import srrw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [FL_W-1:0]  i_dividend,
    input  logic [SEG_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [FL_W-1:0]  o_quot,
    output logic [SEG_W-1:0] o_rem
);

    localparam int STEP_W = $clog2(FL_W);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [SEG_W-1:0]  r_acc;
    logic [FL_W-1:0]   r_q;
    logic [SEG_W-1:0]  r_d;
    logic [SEG_W:0]    trial;
    logic [SEG_W:0]    diff;
    logic              ge;

    always_comb begin
        trial = {r_acc, r_q[FL_W-1]};
        ge    = trial >= {1'b0, r_d};
        diff  = trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(FL_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_acc <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_acc <= ge ? diff[SEG_W-1:0] : trial[SEG_W-1:0];
            r_q   <= {r_q[FL_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_acc;

endmodule

>>> src/srrw_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration, window slots, divider, offset multiplier, result staging.
// Depends on srrw_pkg and srrw_div; driven by commands from srrw_ctrl.
module srrw_dp import srrw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  t_in_item         i_item,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [FL_W-1:0]  i_cfg_data,
    output t_out_item        o_result,
    output logic             o_result_valid
);

    logic [FL_W-1:0]   r_file_len;
    logic [SEG_W-1:0]  r_seg_size;
    logic [SEG_W-1:0]  r_timeout;
    t_in_item          r_item;
    logic [FL_W-1:0]   r_n;
    logic [SEG_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_w;
    logic [FL_W-1:0]   r_seg_arr [WINDOW];
    logic [SEG_W-1:0]  r_tmr_arr [WINDOW];
    logic [WINDOW-1:0] r_rcv;
    logic [SLOT_W-1:0] r_head;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_slot;
    logic [FL_W-1:0]   r_count;
    logic [FL_W-1:0]   r_tail;
    logic [FL_W-1:0]   r_k;
    logic [FL_W-1:0]   r_prod;
    logic              r_active;
    logic [CNT_W-1:0]  r_g;
    logic              r_ok;
    t_out_item         r_hold;
    t_out_item         r_out;
    logic              r_hold_v;
    logic              r_out_v;

    logic              div_go;
    logic [FL_W-1:0]   div_dividend;
    logic              div_busy;
    logic [FL_W-1:0]   div_q;
    logic [SEG_W-1:0]  div_r;

    logic [SEG_W-1:0]        seg_eff;
    logic [FL_W-1:0]         n_calc;
    logic [CNT_W-1:0]        w_calc;
    logic                    idx_in_win;
    logic [FL_W-1:0]         sw_seg;
    logic [FL_W+SEG_W-1:0]   mul;
    logic                    pending_idx;
    logic [SEG_W-1:0]        tmr_dec;
    logic [FL_W-1:0]         base;
    logic [FL_W-1:0]         kdiff;
    logic                    base_ok;
    logic [SUM_W-1:0]        slot_sum;
    logic [SUM_W-1:0]        slot_wrap;
    logic                    slot_ok;
    logic                    dlv_go;
    logic [SEG_W-1:0]        dlv_len;
    logic [SLOT_W-1:0]       head_next;
    logic                    win_ok;
    logic                    count_hit;
    logic                    new_v;
    t_out_item               new_res;
    t_out_item               hold_last;

    srrw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (div_dividend),
        .i_divisor  (seg_eff),
        .o_busy     (div_busy),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    always_comb begin
        seg_eff      = (r_seg_size == '0) ? SEG_W'(1) : r_seg_size;
        div_go       = (i_cmd == CMD_DIV_N) || (i_cmd == CMD_DIV_K);
        div_dividend = (i_cmd == CMD_DIV_K) ? r_item.data_start : r_file_len;

        n_calc = div_q + FL_W'(div_r != '0);
        w_calc = (n_calc < FL_W'(WINDOW)) ? n_calc[CNT_W-1:0] : CNT_W'(WINDOW);

        idx_in_win  = CNT_W'(r_idx) < r_w;
        sw_seg      = (r_item.opcode == OP_START) ? FL_W'(r_idx) : r_seg_arr[r_idx];
        mul         = sw_seg * seg_eff;
        pending_idx = !r_rcv[r_idx] && (r_seg_arr[r_idx] < r_n);
        tmr_dec     = (r_tmr_arr[r_idx] != '0) ? r_tmr_arr[r_idx] - SEG_W'(1) : '0;

        base    = r_seg_arr[r_head];
        kdiff   = div_q - base;
        base_ok = (div_r == '0) && (r_item.data_length == seg_eff) && (div_q < r_n)
                  && (div_q >= base) && (kdiff < FL_W'(r_w));
        slot_sum  = SUM_W'(r_head) + SUM_W'(kdiff[CNT_W-1:0]);
        slot_wrap = (slot_sum >= SUM_W'(r_w)) ? slot_sum - SUM_W'(r_w) : slot_sum;

        slot_ok   = r_ok && !r_rcv[r_slot] && (r_seg_arr[r_slot] == r_k);
        dlv_go    = (r_g < r_w) && r_rcv[r_head];
        dlv_len   = ((r_seg_arr[r_head] == r_n - FL_W'(1)) && (r_rem != '0)) ? r_rem : seg_eff;
        head_next = (CNT_W'(r_head) + CNT_W'(1) == r_w) ? '0 : r_head + SLOT_W'(1);
        win_ok    = r_active && (r_w != '0) && (CNT_W'(r_head) < r_w);
        count_hit = r_count == r_n;

        new_v   = 1'b0;
        new_res = '0;
        unique case (i_cmd)
            CMD_START_INIT: begin
                new_v        = r_n == '0;
                new_res.kind = KIND_DONE;
            end
            CMD_SW_EX: begin
                new_res.kind           = KIND_REQ;
                new_res.request_offset = r_prod;
                new_res.request_length = seg_eff;
                if (r_item.opcode == OP_START) begin
                    new_v = idx_in_win;
                end else begin
                    new_v = idx_in_win && pending_idx && (tmr_dec == '0);
                end
            end
            CMD_IGNORE: begin
                new_v        = 1'b1;
                new_res.kind = KIND_IGN;
            end
            CMD_DLV: begin
                new_v                   = 1'b1;
                new_res.kind            = KIND_DLV;
                new_res.deliver_slot    = 5'(r_head);
                new_res.deliver_segment = r_seg_arr[r_head];
                new_res.deliver_length  = dlv_len;
            end
            CMD_FINISH: begin
                new_v        = count_hit;
                new_res.kind = KIND_DONE;
            end
            default: ;
        endcase

        hold_last      = r_hold;
        hold_last.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_len <= FILE_LEN_RST;
            r_seg_size <= SEG_SIZE_RST;
            r_timeout  <= TIMEOUT_RST;
            r_active   <= 1'b0;
            r_head     <= '0;
            r_count    <= '0;
            r_rcv      <= '0;
            r_idx      <= '0;
            r_g        <= '0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                r_seg_arr[i] <= FL_W'(i);
                r_tmr_arr[i] <= '0;
            end
        end else begin
            r_out_v <= r_hold_v && (new_v || (i_cmd == CMD_FLUSH));
            if (new_v) begin
                r_hold_v <= 1'b1;
            end
            unique case (i_cmd)
                CMD_START_INIT: begin
                    r_active <= r_n != '0;
                    r_head   <= '0;
                    r_count  <= '0;
                    r_idx    <= '0;
                end
                CMD_TICK_INIT: begin
                    r_idx <= '0;
                end
                CMD_SW_EX: begin
                    r_idx <= r_idx + SLOT_W'(1);
                    if (r_item.opcode == OP_START) begin
                        r_seg_arr[r_idx] <= FL_W'(r_idx);
                        r_rcv[r_idx]     <= 1'b0;
                        r_tmr_arr[r_idx] <= idx_in_win ? r_timeout : '0;
                    end else if (idx_in_win && pending_idx) begin
                        r_tmr_arr[r_idx] <= (tmr_dec == '0) ? r_timeout : tmr_dec;
                    end
                end
                CMD_ACCEPT: begin
                    r_rcv[r_slot]     <= 1'b1;
                    r_tmr_arr[r_slot] <= '0;
                    r_count           <= r_count + FL_W'(1);
                    r_g               <= '0;
                end
                CMD_DLV: begin
                    r_seg_arr[r_head] <= r_tail + FL_W'(1);
                    r_tmr_arr[r_head] <= '0;
                    r_rcv[r_head]     <= 1'b0;
                    r_head            <= head_next;
                    r_g               <= r_g + CNT_W'(1);
                end
                CMD_FINISH: begin
                    if (count_hit) begin
                        r_active <= 1'b0;
                    end
                end
                CMD_FLUSH: begin
                    if (r_hold_v) begin
                        r_hold_v <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FILE_LEN: begin
                        r_file_len <= i_cfg_data;
                        r_active   <= 1'b0;
                    end
                    CFG_SEG_SIZE: begin
                        r_seg_size <= i_cfg_data[SEG_W-1:0];
                        r_active   <= 1'b0;
                    end
                    CFG_TIMEOUT: begin
                        r_timeout <= i_cfg_data[SEG_W-1:0];
                        r_active  <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (new_v) begin
            if (r_hold_v) begin
                r_out <= r_hold;
            end
            r_hold <= new_res;
        end
        unique case (i_cmd)
            CMD_LATCH: begin
                r_item <= i_item;
            end
            CMD_SAVE_N: begin
                r_n   <= n_calc;
                r_rem <= div_r;
                r_w   <= w_calc;
            end
            CMD_START_INIT: begin
                r_tail <= FL_W'(r_w) - FL_W'(1);
            end
            CMD_SW_RD: begin
                r_prod <= mul[FL_W-1:0];
            end
            CMD_BASE: begin
                r_k    <= div_q;
                r_ok   <= base_ok;
                r_slot <= slot_wrap[SLOT_W-1:0];
            end
            CMD_DLV: begin
                r_tail <= r_tail + FL_W'(1);
            end
            CMD_FLUSH: begin
                if (r_hold_v) begin
                    r_out <= hold_last;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.op       = r_item.opcode;
        o_status.div_busy = div_busy;
        o_status.active   = r_active;
        o_status.win_ok   = win_ok;
        o_status.idx_last = r_idx == SLOT_W'(WINDOW - 1);
        o_status.slot_ok  = slot_ok;
        o_status.dlv_go   = dlv_go;
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_v;

endmodule

>>> src/srrw_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences division, slot sweep, data check and delivery.
// Depends on srrw_pkg; commands srrw_dp.
module srrw_ctrl import srrw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd   = CMD_LATCH;
                    n_state = ST_DIV_N;
                end
            end
            ST_DIV_N: begin
                o_cmd   = CMD_DIV_N;
                n_state = ST_WAIT_N;
            end
            ST_WAIT_N: begin
                if (!i_status.div_busy) begin
                    o_cmd   = CMD_SAVE_N;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority if (i_status.op == OP_START) begin
                    o_cmd   = CMD_START_INIT;
                    n_state = ST_SW_RD;
                end else if (i_status.op == OP_TICK) begin
                    if (i_status.active) begin
                        o_cmd   = CMD_TICK_INIT;
                        n_state = ST_SW_RD;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end else if (i_status.op == OP_DATA) begin
                    if (i_status.win_ok) begin
                        n_state = ST_DIV_K;
                    end else begin
                        o_cmd   = CMD_IGNORE;
                        n_state = ST_FLUSH;
                    end
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_SW_RD: begin
                o_cmd   = CMD_SW_RD;
                n_state = ST_SW_EX;
            end
            ST_SW_EX: begin
                o_cmd   = CMD_SW_EX;
                n_state = i_status.idx_last ? ST_FLUSH : ST_SW_RD;
            end
            ST_DIV_K: begin
                o_cmd   = CMD_DIV_K;
                n_state = ST_WAIT_K;
            end
            ST_WAIT_K: begin
                if (!i_status.div_busy) begin
                    n_state = ST_BASE;
                end
            end
            ST_BASE: begin
                o_cmd   = CMD_BASE;
                n_state = ST_SLOT;
            end
            ST_SLOT: begin
                if (i_status.slot_ok) begin
                    o_cmd   = CMD_ACCEPT;
                    n_state = ST_DLV;
                end else begin
                    o_cmd   = CMD_IGNORE;
                    n_state = ST_FLUSH;
                end
            end
            ST_DLV: begin
                if (i_status.dlv_go) begin
                    o_cmd = CMD_DLV;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd   = CMD_FINISH;
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                o_cmd   = CMD_FLUSH;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != ST_IDLE;

endmodule

>>> src/selective_repeat_receive_window.sv
`timescale 1ns / 1ps
// Top level of the selective-repeat receive window: controller plus datapath.
// Start, and tick while active: segment-count divide, then a read/execute sweep over all 16 slots.
// Data: segment-count divide, then if the window is open an offset divide, slot check and delivery.
// A result shows for one cycle, the cycle after its successor or flush; the receiver cannot stall.
// Synchronous active-low reset restores the registers' defaults and an empty, inactive window.
module selective_repeat_receive_window import srrw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in_item    i_item,
    output t_out_item   o_result,
    output logic        o_result_valid,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    srrw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    srrw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_item         (i_item),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    assign o_cfg_ready = 1'b1;

endmodule

>>> src/srrw_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the selective-repeat receive window, bound to the top level.
// Depends on srrw_pkg.
module srrw_port_checker import srrw_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input t_out_item o_result,
    input logic      o_result_valid
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid && !o_busy)
        else $error("result or busy after reset");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted without going busy");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.kind == KIND_IGN || o_result.kind == KIND_DONE))
        |-> o_result.last)
        else $error("ignore or completion not marked last");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_busy) |-> o_result.last)
        else $error("non-final result while idle");

    a_req_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.kind == KIND_REQ)
        |-> (o_result.request_length != '0 && o_result.deliver_length == '0))
        else $error("malformed request result");

endmodule

bind selective_repeat_receive_window srrw_port_checker u_srrw_port_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result       (o_result),
    .o_result_valid (o_result_valid)
);

>>> bench/srrw_checker.sv
`timescale 1ns / 1ps
// Checker for the selective-repeat receive window: watches the request, result and
// configuration channels, predicts every result and compares. Depends on srrw_pkg.
module srrw_checker import srrw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_in_item    i_item,
    input  t_out_item   i_result,
    input  logic        i_result_valid,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_expected_left,
    output logic [23:0] o_window_base
);

    logic [23:0] file_len;
    logic [15:0] seg_size;
    logic [15:0] timeout;
    logic [23:0] slot_seg [WINDOW];
    logic [15:0] slot_tmr [WINDOW];
    logic        slot_rcv [WINDOW];
    int unsigned head;
    logic [23:0] rcv_count;
    logic        active;

    t_out_item   result_q[$];
    int          fails;

    assign o_fail_count    = fails;
    assign o_expected_left = result_q.size();
    assign o_window_base   = slot_seg[head];

    task automatic report(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    task automatic clear_window();
        for (int i = 0; i < WINDOW; i++) begin
            slot_seg[i] = 24'(i);
            slot_tmr[i] = '0;
            slot_rcv[i] = 1'b0;
        end
        head      = 0;
        rcv_count = '0;
    endtask

    task automatic push_result(t_kind kind, logic [23:0] roff, logic [15:0] rlen,
                               logic [4:0] dslot, logic [23:0] dseg, logic [15:0] dlen);
        t_out_item r;
        r.kind            = kind;
        r.request_offset  = roff;
        r.request_length  = rlen;
        r.deliver_slot    = dslot;
        r.deliver_segment = dseg;
        r.deliver_length  = dlen;
        r.last            = 1'b0;
        result_q.push_back(r);
    endtask

    task automatic push_request(int unsigned i, int unsigned seg);
        push_result(KIND_REQ, 24'(slot_seg[i] * seg), 16'(seg), '0, '0, '0);
        slot_tmr[i] = timeout;
    endtask

    task automatic predict_window(t_in_item it);
        int unsigned seg, n, w, k, base, slot, len, h, prior;
        bit ok;
        seg   = (seg_size == 0) ? 1 : seg_size;
        n     = (file_len + seg - 1) / seg;
        w     = (n < WINDOW) ? n : WINDOW;
        prior = result_q.size();
        case (it.opcode)
            OP_START: begin
                clear_window();
                if (n == 0) begin
                    active = 1'b0;
                    push_result(KIND_DONE, '0, '0, '0, '0, '0);
                end else begin
                    active = 1'b1;
                    for (int unsigned i = 0; i < w; i++)
                        if (!slot_rcv[i] && slot_seg[i] < n) push_request(i, seg);
                end
            end
            OP_TICK: begin
                if (active) begin
                    for (int unsigned i = 0; i < w; i++) begin
                        if (slot_rcv[i] || slot_seg[i] >= n) continue;
                        if (slot_tmr[i] > 0) slot_tmr[i]--;
                        if (slot_tmr[i] == 0) push_request(i, seg);
                    end
                end
            end
            OP_DATA: begin
                ok   = active && w > 0 && head < w;
                k    = it.data_start / seg;
                slot = 0;
                if (ok) begin
                    base = slot_seg[head];
                    ok = (it.data_start % seg == 0) && it.data_length == seg && k < n &&
                         k >= base && (k - base) < w;
                    if (ok) begin
                        slot = (head + (k - base)) % w;
                        ok   = !slot_rcv[slot] && slot_seg[slot] == k;
                    end
                end
                if (!ok) begin
                    push_result(KIND_IGN, '0, '0, '0, '0, '0);
                end else begin
                    slot_rcv[slot] = 1'b1;
                    slot_tmr[slot] = '0;
                    rcv_count++;
                    for (int unsigned g = 0; g < w && slot_rcv[head]; g++) begin
                        h   = head;
                        len = seg;
                        if (slot_seg[h] == n - 1 && file_len % seg != 0) len = file_len % seg;
                        push_result(KIND_DLV, '0, '0, 5'(h), slot_seg[h], 16'(len));
                        slot_seg[h] = 24'(slot_seg[(h + w - 1) % w] + 1);
                        slot_tmr[h] = '0;
                        slot_rcv[h] = 1'b0;
                        head        = (h + 1) % w;
                    end
                    if (rcv_count == n) begin
                        push_result(KIND_DONE, '0, '0, '0, '0, '0);
                        active = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (result_q.size() > prior) result_q[$].last = 1'b1;
    endtask

    task automatic compare_result(t_out_item got);
        t_out_item want;
        if (result_q.size() == 0) begin
            report("unexpected result kind", 24'(got.kind), '0);
            return;
        end
        want = result_q.pop_front();
        if (got.kind != want.kind) report("kind", 24'(got.kind), 24'(want.kind));
        if (got.request_offset != want.request_offset)
            report("request_offset", got.request_offset, want.request_offset);
        if (got.request_length != want.request_length)
            report("request_length", 24'(got.request_length), 24'(want.request_length));
        if (got.deliver_slot != want.deliver_slot)
            report("deliver_slot", 24'(got.deliver_slot), 24'(want.deliver_slot));
        if (got.deliver_segment != want.deliver_segment)
            report("deliver_segment", got.deliver_segment, want.deliver_segment);
        if (got.deliver_length != want.deliver_length)
            report("deliver_length", 24'(got.deliver_length), 24'(want.deliver_length));
        if (got.last != want.last) report("last", 24'(got.last), 24'(want.last));
    endtask

    initial begin
        fails = 0;
        file_len = FILE_LEN_RST;
        seg_size = SEG_SIZE_RST;
        timeout  = TIMEOUT_RST;
        active   = 1'b0;
        clear_window();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            file_len = FILE_LEN_RST;
            seg_size = SEG_SIZE_RST;
            timeout  = TIMEOUT_RST;
            active   = 1'b0;
            clear_window();
            result_q.delete();
        end else begin
            if (i_result_valid) compare_result(i_result);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FILE_LEN: begin file_len = i_cfg_data;        active = 1'b0; end
                    CFG_SEG_SIZE: begin seg_size = i_cfg_data[15:0];  active = 1'b0; end
                    CFG_TIMEOUT:  begin timeout  = i_cfg_data[15:0];  active = 1'b0; end
                    default: ;
                endcase
            end
            if (i_start && !i_busy) predict_window(i_item);
        end
    end

endmodule

>>> bench/selective_repeat_receive_window_test.sv
`timescale 1ns / 1ps
// Top of the selective-repeat receive window test: clock, reset, directed and random
// requests and configuration phases. Depends on srrw_pkg, the block and srrw_checker.
module selective_repeat_receive_window_test;
    import srrw_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in_item    i_item;
    t_out_item   o_result;
    logic        o_result_valid;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    int          fail_count;
    int          expected_left;
    logic [23:0] window_base;
    bit          calm;
    int unsigned cur_seg;

    selective_repeat_receive_window u_top (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_item, .o_result, .o_result_valid,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    srrw_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_item, .i_result(o_result),
        .i_result_valid(o_result_valid), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count),
        .o_expected_left(expected_left), .o_window_base(window_base)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("selective_repeat_receive_window_test NOT OK");
        $finish;
    end

    task automatic send_request(logic [1:0] op, logic [23:0] dstart, logic [15:0] dlen);
        if (!calm && $urandom_range(0, 99) < 38) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start            <= 1'b1;
        i_item.opcode      <= op;
        i_item.data_start  <= dstart;
        i_item.data_length <= dlen;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (expected_left != 0 || o_busy);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(logic [23:0] flen, logic [15:0] seg, logic [15:0] tmo);
        drain();
        write_reg(CFG_FILE_LEN, flen);
        write_reg(CFG_SEG_SIZE, {8'($urandom), seg});
        write_reg(CFG_TIMEOUT, {8'($urandom), tmo});
        i_cfg_valid <= 1'b0;
        cur_seg = (seg == 0) ? 1 : seg;
    endtask

    task automatic send_data(int unsigned k);
        send_request(OP_DATA, 24'(k * cur_seg), 16'(cur_seg));
    endtask

    task automatic random_phase(int count);
        int unsigned r, k;
        send_request(OP_START, 24'($urandom), 16'($urandom));
        for (int j = 0; j < count; j++) begin
            r = $urandom_range(0, 99);
            k = window_base + $urandom_range(0, 17);
            if (r < 55) send_data(k);
            else if (r < 75) send_request(OP_TICK, 24'($urandom), 16'($urandom));
            else if (r < 80) send_request(OP_START, 24'($urandom), 16'($urandom));
            else if (r < 85) send_request(OP_DATA, 24'(k * cur_seg + 1), 16'(cur_seg));
            else if (r < 90) send_request(OP_DATA, 24'(k * cur_seg), 16'(cur_seg + 1));
            else send_request(2'($urandom), 24'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FILE_LEN;
        i_cfg_data  = '0;
        calm        = 1'b0;
        cur_seg     = SEG_SIZE_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: one short segment
        send_request(OP_START, '0, '0);
        send_request(OP_TICK, '0, '0);
        send_data(0);
        send_data(0);
        send_request(OP_TICK, 24'hffffff, 16'hffff);
        send_request(2'd3, 24'hffffff, 16'hffff);

        // short last segment, out-of-order, duplicate and bad arrivals
        configure(24'd37, 16'd8, 16'd2);
        send_request(OP_START, '0, '0);
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '0, '0);
        send_data(1);
        send_data(0);
        send_data(0);
        send_request(OP_DATA, 24'd17, 16'd8);
        send_request(OP_DATA, 24'd16, 16'd7);
        send_data(20);
        send_data(4);
        send_request(OP_START, '0, '0);
        for (int k = 0; k < 5; k++) send_data(k);
        send_request(OP_TICK, '0, '0);
        send_data(0);

        // zero segment size and empty file
        configure(24'd0, 16'd0, 16'd0);
        send_request(OP_START, '0, '0);
        send_request(OP_TICK, '0, '0);

        configure(24'd20, 16'd0, 16'd0);
        random_phase(45);
        configure(24'd40, 16'd3, 16'd1);
        random_phase(45);
        calm = 1'b1;
        configure(24'd300, 16'd10, 16'd4);
        random_phase(50);
        calm = 1'b0;
        configure(24'hffffff, 16'hffff, 16'hffff);
        random_phase(45);
        configure(24'hffffff, 16'd1, 16'd0);
        random_phase(45);
        configure(24'd1000, 16'd64, 16'd3);
        random_phase(50);
        configure(24'd5, 16'd2, 16'd1);
        random_phase(45);
        configure(24'd1, 16'hffff, 16'd2);
        random_phase(20);

        drain();
        if (fail_count == 0) begin
            $display("selective_repeat_receive_window_test OK");
        end else begin
            $display("selective_repeat_receive_window_test NOT OK");
        end
        $finish;
    end

endmodule
